>>> hw/rtl/ufs_pkg.sv
package ufs_pkg;

	localparam int unsigned UFS_NODES = 65536;
	localparam int unsigned ELEM_W    = 16;
	localparam int unsigned CFG_W     = 17;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned PADDR_W   = 3;

	localparam logic [CFG_W-1:0] NUM_ELEMENTS_RST = 17'd65536;

	// register index, taken from paddr[2]
	localparam logic REG_NUM_ELEMENTS = 1'b0;

	localparam logic REQ_QUERY = 1'b0;
	localparam logic REQ_UNION = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic              same_set;
		logic [ELEM_W-1:0] root_of_a;
		logic [ELEM_W-1:0] root_of_b;
		logic              status;
	} rsp_t;

endpackage

>>> hw/rtl/ufs_if.sv
interface ufs_req_if import ufs_pkg::*;;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ELEM_W-1:0] elem_a;
	logic [ELEM_W-1:0] elem_b;

	modport source (output valid, output req_type, output elem_a, output elem_b, input ready);
	modport sink   (input valid, input req_type, input elem_a, input elem_b, output ready);
endinterface

interface ufs_rsp_if import ufs_pkg::*;;
	logic              valid;
	logic              ready;
	logic              same_set;
	logic [ELEM_W-1:0] root_of_a;
	logic [ELEM_W-1:0] root_of_b;
	logic              status;

	modport source (output valid, output same_set, output root_of_a, output root_of_b,
		output status, input ready);
	modport sink   (input valid, input same_set, input root_of_a, input root_of_b,
		input status, output ready);
endinterface

>>> hw/rtl/union_find_by_size_unit.sv
// union-find store with union by size, no path compression
// req channel: req_type (query or union), elem_a, elem_b; taken on valid && ready
// rsp channel: same_set, root_of_a, root_of_b, status; exactly one response per request
// apb port: register num_elements at byte address 0, written in the access phase
// an element at or above num_elements gives status 1 with zero roots and no change
// a request walks from elem_a to its root, then from elem_b to its root, and a union of
// two different roots then writes the new parent link and the new size; union by size
// keeps each tree depth at most log2(NODES)
// the single memory port reads one parent link per cycle
// one request is in work at a time; a new one is taken while the last response still
// waits in the output register
// after reset the store is cleared, one entry per cycle, and req.ready
// stays low until then; num_elements resets to 65536
// when the receiver stalls, the output register holds; a finished response then waits in
// the sequencer and no new request is taken until the output register frees up
module union_find_by_size_unit import ufs_pkg::*; #(
	parameter int unsigned NODES = UFS_NODES
) (
	input  logic               clk,
	input  logic               arst_n,
	ufs_req_if.sink            req,
	ufs_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	localparam int unsigned AW = $clog2(NODES);
	localparam int unsigned DW = 2 * AW + 1;

	logic [CFG_W-1:0] num_elements_q;
	logic             rsp_valid_q;
	rsp_t             rsp_data_q;

	logic             res_valid;
	logic             res_ready;
	rsp_t             res;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [DW-1:0]    mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [DW-1:0]    mem_rdata;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_NUM_ELEMENTS) ? APB_DW'(num_elements_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_elements_q <= NUM_ELEMENTS_RST;
		end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_NUM_ELEMENTS)) begin
			num_elements_q <= pwdata[CFG_W-1:0];
		end
	end

	ufs_ctrl #(
		.NODES(NODES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.num_elements(num_elements_q),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.req_type    (req.req_type),
		.elem_a      (req.elem_a),
		.elem_b      (req.elem_b),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	ufs_mem #(
		.NODES(NODES),
		.DW   (DW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.same_set  = rsp_data_q.same_set;
	assign rsp.root_of_a = rsp_data_q.root_of_a;
	assign rsp.root_of_b = rsp_data_q.root_of_b;
	assign rsp.status    = rsp_data_q.status;

endmodule

>>> hw/rtl/ufs_mem.sv
module ufs_mem import ufs_pkg::*; #(
	parameter int unsigned NODES = UFS_NODES,
	parameter int unsigned DW    = 2 * $clog2(UFS_NODES) + 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(NODES)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(NODES)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [NODES];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/ufs_ctrl.sv
module ufs_ctrl import ufs_pkg::*; #(
	parameter int unsigned NODES = UFS_NODES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [CFG_W-1:0]                       num_elements,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   req_type,
	input  logic [ELEM_W-1:0]                      elem_a,
	input  logic [ELEM_W-1:0]                      elem_b,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output rsp_t                                   res,
	output logic                                   mem_we,
	output logic [$clog2(NODES)-1:0]               mem_waddr,
	output logic [2*$clog2(NODES):0]               mem_wdata,
	output logic [$clog2(NODES)-1:0]               mem_raddr,
	input  logic [2*$clog2(NODES):0]               mem_rdata
);

	localparam int unsigned AW = $clog2(NODES);
	localparam int unsigned SW = AW + 1;

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_WALK_A = 7'b0000100,
		S_WALK_B = 7'b0001000,
		S_LINK   = 7'b0010000,
		S_GROW   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic          union_q;
	logic [AW-1:0] cur_q, b_q, ra_q, rb_q;
	logic [SW-1:0] sa_q, sb_q;
	rsp_t          res_q;

	logic [AW-1:0] rd_par;
	logic [SW-1:0] rd_size;
	logic [SW-1:0] size_sum;
	logic          at_root;
	logic          a_small;
	logic          in_range;

	assign rd_par   = mem_rdata[AW-1:0];
	assign rd_size  = mem_rdata[SW+AW-1:AW];
	assign at_root  = (rd_par == cur_q);
	assign a_small  = (sa_q < sb_q);
	assign size_sum = sa_q + sb_q;
	assign in_range = (CFG_W'(elem_a) < num_elements) && (CFG_W'(elem_b) < num_elements)
		&& (32'(elem_a) < NODES) && (32'(elem_b) < NODES);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = {SW'(1), cnt_q};
		mem_raddr = cur_q;
		unique case (state_q)
			S_INIT: begin
				// clearing pass: every entry its own root of size one
				mem_we = 1'b1;
				if (cnt_q == AW'(NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready  = 1'b1;
				mem_raddr = AW'(elem_a);
				if (in_valid) begin
					state_d = in_range ? S_WALK_A : S_DONE;
				end
			end
			S_WALK_A: begin
				if (at_root) begin
					mem_raddr = b_q;
					state_d   = S_WALK_B;
				end else begin
					mem_raddr = rd_par;
				end
			end
			S_WALK_B: begin
				if (at_root) begin
					state_d = (union_q && (cur_q != ra_q)) ? S_LINK : S_DONE;
				end else begin
					mem_raddr = rd_par;
				end
			end
			S_LINK: begin
				// hang the smaller root under the larger one
				mem_we = 1'b1;
				if (a_small) begin
					mem_waddr = ra_q;
					mem_wdata = {sa_q, rb_q};
				end else begin
					mem_waddr = rb_q;
					mem_wdata = {sb_q, ra_q};
				end
				state_d = S_GROW;
			end
			S_GROW: begin
				mem_we = 1'b1;
				if (a_small) begin
					mem_waddr = rb_q;
					mem_wdata = {size_sum, rb_q};
				end else begin
					mem_waddr = ra_q;
					mem_wdata = {size_sum, ra_q};
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					union_q <= (req_type == REQ_UNION);
					cur_q   <= AW'(elem_a);
					b_q     <= AW'(elem_b);
					if (!in_range) begin
						res_q.same_set  <= 1'b0;
						res_q.root_of_a <= '0;
						res_q.root_of_b <= '0;
						res_q.status    <= STATUS_RANGE;
					end
				end
			end
			S_WALK_A: begin
				if (at_root) begin
					ra_q  <= cur_q;
					sa_q  <= rd_size;
					cur_q <= b_q;
				end else begin
					cur_q <= rd_par;
				end
			end
			S_WALK_B: begin
				if (at_root) begin
					rb_q            <= cur_q;
					sb_q            <= rd_size;
					res_q.same_set  <= (cur_q == ra_q);
					res_q.root_of_a <= ELEM_W'(ra_q);
					res_q.root_of_b <= ELEM_W'(cur_q);
					res_q.status    <= STATUS_OK;
				end else begin
					cur_q <= rd_par;
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule
